// ===== rtl/tcce_pkg.sv =====
package tcce_pkg;

  // widths fixed by the item formats
  localparam int BYTE_W   = 8;
  localparam int PIX_W    = 13;
  localparam int ARGB_W   = 32;
  localparam int COL_W    = 9;
  localparam int ROW_W    = 9;
  localparam int NCOLS_W  = 10;
  localparam int NROWS_W  = 9;
  localparam int LEFT_W   = 9;
  localparam int TOP_W    = 8;
  localparam int CNT_W    = 3;

  localparam int CELL_WIDTH_DEF  = 8;
  localparam int CELL_HEIGHT_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int MAX_RESULTS = 5;
  localparam int TAB_SPACES  = 4;

  localparam logic [7:0] ASCII_LIMIT  = 8'h80;
  localparam logic [7:0] LEAD_MASK    = 8'hE0;
  localparam logic [7:0] LEAD_MATCH   = 8'hC0;
  localparam logic [7:0] LEAD_C3      = 8'hC3;
  localparam logic [7:0] LEAD_C4      = 8'hC4;
  localparam logic [7:0] LEAD_C5      = 8'hC5;
  localparam logic [7:0] OPACITY_FULL = 8'd255;
  localparam logic [7:0] CH_QUESTION  = 8'h3F;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_LF        = 8'd10;
  localparam logic [7:0] CH_CR        = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  typedef enum logic [1:0] {
    CMD_UTF8 = 2'd0,
    CMD_RAW  = 2'd1,
    CMD_HOME = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_COLUMNS = 3'd0,
    REG_ROWS    = 3'd1,
    REG_LEFT    = 3'd2,
    REG_TOP     = 3'd3,
    REG_FG      = 3'd4,
    REG_BG      = 3'd5,
    REG_OPACITY = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_HOME,
    OP_CR,
    OP_LF,
    OP_TAB,
    OP_CELL
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic [BYTE_W-1:0] glyph;
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CELL,
    BK_SCROLL
  } back_state_t;

  typedef enum logic {
    EV_CELL   = 1'b0,
    EV_SCROLL = 1'b1
  } event_kind_t;

  typedef struct packed {
    logic [NCOLS_W-1:0] cols;
    logic [NROWS_W-1:0] rows;
    logic [LEFT_W-1:0]  left;
    logic [TOP_W-1:0]   top;
    logic [ARGB_W-1:0]  fg;
    logic [ARGB_W-1:0]  bg;
  } cfg_view_t;

  typedef struct packed {
    event_kind_t        kind;
    logic [PIX_W-1:0]   px;
    logic [PIX_W-1:0]   py;
    logic [BYTE_W-1:0]  glyph;
    logic [ARGB_W-1:0]  fore;
    logic [ARGB_W-1:0]  back;
    logic               last;
  } result_t;

endpackage

// ===== rtl/text_console_cursor_engine.sv =====
// Text console cursor engine. Console bytes come in on the in_ stream (tuser
// = command, tdata = byte, tlast = last byte of a string) and cell draws and
// scroll events leave on the out_ stream, at most one result per cycle while
// out_tready is high. An item is accepted in every cycle while the op queue
// between decoder and sequencer (four deep by default) has room; the decoder
// never stalls. The back end pops a printable character, draws its cell, then
// scrolls if it wrapped on the last row; a tab is popped, then expanded one
// result at a time; newline, carriage return and home act at the pop, a
// newline on the last row emitting a scroll. No op is popped until all results
// of the last one are emitted. Region geometry, colours and opacity must be
// written over the APB port only while the block is idle (not enforced by the
// block); scaled colours are registered and follow a write in the next cycle.
module text_console_cursor_engine
  import tcce_pkg::*;
#(
  parameter int CELL_WIDTH  = CELL_WIDTH_DEF,
  parameter int CELL_HEIGHT = CELL_HEIGHT_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] byte_value
  input  logic [1:0]   in_tuser,   // [1:0] cmd
  input  logic         in_tlast,   // string_end
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // [12:0] pixel_x, [25:13] pixel_y, [33:26] glyph_code,
                                   // [65:34] fore_out, [97:66] back_out, rest zero
  output logic         out_tuser,  // event_kind
  output logic         out_tlast,  // final_event
  // configuration
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  cfg_view_t cfg_view;
  op_t       push_op, q_head;
  logic      push, q_pop, q_empty, q_full;
  result_t   res;

  tcce_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .view    (cfg_view)
  );

  // front: UTF-8 decode, lead byte held here, bytes classified into ops
  tcce_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_cmd   (in_tuser),
    .in_byte  (in_tdata),
    .in_end   (in_tlast),
    .q_full   (q_full),
    .in_ready (in_tready),
    .push     (push),
    .op       (push_op)
  );

  tcce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty),
    .full    (q_full)
  );

  // back: cursor, wrap and scroll, tab expansion, at most one result per cycle while out_ready is high
  tcce_back #(
    .CELL_WIDTH  (CELL_WIDTH),
    .CELL_HEIGHT (CELL_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_view),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res)
  );

  assign out_tdata = {6'd0, res.back, res.fore, res.glyph, res.py, res.px};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

  // a scroll carries no x position, glyph or fore colour
  a_scroll_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == EV_SCROLL |->
      out_tdata[12:0] == '0 && out_tdata[33:26] == '0 && out_tdata[65:34] == '0)
    else $error("scroll event with cell payload");

  // control codes never reach a cell draw
  a_no_ctrl_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == EV_CELL |->
      out_tdata[33:26] != CH_LF && out_tdata[33:26] != CH_CR &&
      out_tdata[33:26] != CH_TAB)
    else $error("control code drawn as a cell");

  // the results of one item leave back to back
  a_run_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside the results of one item");

  // no op is dropped at the queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("op pushed into a full queue");

endmodule

// ===== rtl/tcce_regs.sv =====
module tcce_regs
  import tcce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_view_t   view
);

  logic [NCOLS_W-1:0] cols_r;
  logic [NROWS_W-1:0] rows_r;
  logic [LEFT_W-1:0]  left_r;
  logic [TOP_W-1:0]   top_r;
  logic [ARGB_W-1:0]  fg_r, bg_r;
  logic [7:0]         opa_r;
  logic [ARGB_W-1:0]  fg_scaled_r, bg_scaled_r;
  reg_idx_t           idx;
  logic               wr;

  // floor(c * lv / 255) by reciprocal: exact for all 8-bit by 8-bit products
  function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [7:0] lv);
    logic [15:0] p;
    logic [16:0] s;
    p = 16'(c) * 16'(lv);
    s = {1'b0, p} + 17'(p[15:8]) + 17'd1;
    return s[15:8];
  endfunction

  function automatic logic [31:0] scale_argb(input logic [31:0] c, input logic [7:0] lv);
    if (lv == OPACITY_FULL) return c;
    return {c[31:24], scale_chan(c[23:16], lv), scale_chan(c[15:8], lv),
            scale_chan(c[7:0], lv)};
  endfunction

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= NCOLS_W'(80);
      rows_r <= NROWS_W'(25);
      left_r <= '0;
      top_r  <= '0;
      fg_r   <= 32'h00FF_FFFF;
      bg_r   <= '0;
      opa_r  <= OPACITY_FULL;
    end else if (wr) begin
      case (idx)
        REG_COLUMNS: cols_r <= pwdata[NCOLS_W-1:0];
        REG_ROWS:    rows_r <= pwdata[NROWS_W-1:0];
        REG_LEFT:    left_r <= pwdata[LEFT_W-1:0];
        REG_TOP:     top_r  <= pwdata[TOP_W-1:0];
        REG_FG:      fg_r   <= pwdata;
        REG_BG:      bg_r   <= pwdata;
        REG_OPACITY: opa_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // scaled colours are registered and follow the registers in the next cycle
  always_ff @(posedge clk) begin
    fg_scaled_r <= scale_argb(fg_r, opa_r);
    bg_scaled_r <= scale_argb(bg_r, opa_r);
  end

  always_comb begin
    case (idx)
      REG_COLUMNS: prdata = 32'(cols_r);
      REG_ROWS:    prdata = 32'(rows_r);
      REG_LEFT:    prdata = 32'(left_r);
      REG_TOP:     prdata = 32'(top_r);
      REG_FG:      prdata = fg_r;
      REG_BG:      prdata = bg_r;
      REG_OPACITY: prdata = 32'(opa_r);
      default:     prdata = '0;
    endcase
  end

  assign view = '{cols: cols_r, rows: rows_r, left: left_r, top: top_r,
                  fg: fg_scaled_r, bg: bg_scaled_r};

endmodule

// ===== rtl/tcce_front.sv =====
module tcce_front
  import tcce_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_cmd,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_end,
  input  logic              q_full,
  output logic              in_ready,
  output logic              push,
  output op_t               op
);

  logic [BYTE_W-1:0] lead_r, lead_nxt;
  logic              waiting_r, waiting_nxt;
  logic              accept;
  logic              have_code;
  logic [BYTE_W-1:0] code;
  cmd_t              cmd;

  function automatic logic [7:0] pair_code(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = CH_QUESTION;
    if (a == LEAD_C3) begin
      case (b)
        8'h87: r = 8'd195;
        8'hA7: r = 8'd231;
        8'h96: r = 8'd214;
        8'hB6: r = 8'd246;
        8'h9C: r = 8'd220;
        8'hBC: r = 8'd252;
        default: r = CH_QUESTION;
      endcase
    end else if (a == LEAD_C4) begin
      case (b)
        8'h9E: r = 8'd196;
        8'h9F: r = 8'd240;
        8'hB0: r = 8'd197;
        8'hB1: r = 8'd253;
        default: r = CH_QUESTION;
      endcase
    end else if (a == LEAD_C5) begin
      case (b)
        8'h9E: r = 8'd222;
        8'h9F: r = 8'd254;
        default: r = CH_QUESTION;
      endcase
    end
    return r;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cmd      = cmd_t'(in_cmd);

  always_comb begin
    lead_nxt    = lead_r;
    waiting_nxt = waiting_r;
    have_code   = 1'b0;
    code        = in_byte;
    push        = 1'b0;
    op          = '{kind: OP_CELL, glyph: in_byte};
    if (accept) begin
      case (cmd)
        CMD_UTF8: begin
          have_code = 1'b1;
          if (waiting_r) begin
            waiting_nxt = 1'b0;
            code        = pair_code(lead_r, in_byte);
          end else if (in_byte < ASCII_LIMIT) begin
            code = in_byte;
          end else if ((in_byte & LEAD_MASK) == LEAD_MATCH) begin
            if (in_end) begin
              code = CH_QUESTION;
            end else begin
              have_code   = 1'b0;
              lead_nxt    = in_byte;
              waiting_nxt = 1'b1;
            end
          end else begin
            code = CH_QUESTION;
          end
        end
        CMD_RAW: begin
          have_code = 1'b1;
          code      = in_byte;
        end
        CMD_HOME: begin
          waiting_nxt = 1'b0;
          lead_nxt    = '0;
          push        = 1'b1;
          op.kind     = OP_HOME;
        end
        default: ;
      endcase
      if (have_code) begin
        push     = 1'b1;
        op.glyph = code;
        if (code == CH_LF)       op.kind = OP_LF;
        else if (code == CH_CR)  op.kind = OP_CR;
        else if (code == CH_TAB) op.kind = OP_TAB;
        else                     op.kind = OP_CELL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r    <= '0;
      waiting_r <= 1'b0;
    end else begin
      lead_r    <= lead_nxt;
      waiting_r <= waiting_nxt;
    end
  end

endmodule

// ===== rtl/tcce_queue.sv =====
module tcce_queue
  import tcce_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output op_t  head,
  output logic empty,
  output logic full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  op_t               mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0] count_r;
  logic              do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_QW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push)
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (do_pop)
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      if (do_push && !do_pop)      count_r <= count_r + CNT_QW'(1);
      else if (do_pop && !do_push) count_r <= count_r - CNT_QW'(1);
    end
  end

endmodule

// ===== rtl/tcce_back.sv =====
module tcce_back
  import tcce_pkg::*;
#(
  parameter int CELL_WIDTH  = CELL_WIDTH_DEF,
  parameter int CELL_HEIGHT = CELL_HEIGHT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_view_t cfg,
  input  op_t       q_head,
  input  logic      q_empty,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   out_data
);

  back_state_t       state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [BYTE_W-1:0] glyph_r, glyph_nxt;
  logic [2:0]        spaces_r, spaces_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              more_r, more_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_data_r, out_data_nxt;

  logic              slot_free, emit;
  result_t           em, scroll_res;
  logic [NCOLS_W-1:0] col_p1, ncol_p1;
  logic [NROWS_W:0]  row_p1, nrow_p1;
  logic              wrap, row_hit, sc;
  logic [COL_W-1:0]  new_col;
  logic [ROW_W-1:0]  new_row;
  logic [3:0]        need_next, cnt_after;
  logic              more;
  logic [NCOLS_W-1:0] sum_x, sum_y;
  logic [31:0]       px_full, py_full, pys_full;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    col_p1  = {1'b0, col_r} + NCOLS_W'(1);
    row_p1  = {1'b0, row_r} + 10'd1;
    wrap    = col_p1 >= cfg.cols;
    row_hit = row_p1 >= {1'b0, cfg.rows};
    sc      = wrap && row_hit;
    new_col = wrap ? '0 : col_p1[COL_W-1:0];
    // a scroll puts the row back where it was
    new_row = (wrap && !sc) ? row_p1[ROW_W-1:0] : row_r;
    ncol_p1 = {1'b0, new_col} + NCOLS_W'(1);
    nrow_p1 = {1'b0, new_row} + 10'd1;
    need_next = 4'd1 + 4'((ncol_p1 >= cfg.cols) && (nrow_p1 >= {1'b0, cfg.rows}));
    cnt_after = {1'b0, cnt_r} + 4'd1 + 4'(sc);
    more      = (spaces_r > 3'd1) && ((cnt_after + need_next) <= 4'(MAX_RESULTS));

    sum_x    = 10'(cfg.left) + 10'(col_r);
    sum_y    = 10'(cfg.top) + 10'(row_r);
    px_full  = 32'(sum_x) * 32'(CELL_WIDTH);
    py_full  = 32'(sum_y) * 32'(CELL_HEIGHT);
    pys_full = 32'(cfg.top) * 32'(CELL_HEIGHT);

    scroll_res = '{kind: EV_SCROLL, px: '0, py: pys_full[PIX_W-1:0], glyph: '0,
                   fore: '0, back: '0, last: 1'b1};
  end

  always_comb begin
    state_nxt  = state_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    glyph_nxt  = glyph_r;
    spaces_nxt = spaces_r;
    cnt_nxt    = cnt_r;
    more_nxt   = more_r;
    q_pop      = 1'b0;
    emit       = 1'b0;
    em         = scroll_res;

    case (state_r)
      BK_IDLE: begin
        if (slot_free && !q_empty) begin
          q_pop = 1'b1;
          case (q_head.kind)
            OP_HOME: begin
              col_nxt = '0;
              row_nxt = '0;
            end
            OP_CR: col_nxt = '0;
            OP_LF: begin
              col_nxt = '0;
              if (row_hit) emit = 1'b1;
              else         row_nxt = row_p1[ROW_W-1:0];
            end
            OP_TAB: begin
              glyph_nxt  = CH_SPACE;
              spaces_nxt = 3'(TAB_SPACES);
              cnt_nxt    = '0;
              state_nxt  = BK_CELL;
            end
            OP_CELL: begin
              glyph_nxt  = q_head.glyph;
              spaces_nxt = 3'd1;
              cnt_nxt    = '0;
              state_nxt  = BK_CELL;
            end
            default: ;
          endcase
        end
      end
      BK_CELL: begin
        if (slot_free) begin
          emit       = 1'b1;
          em         = '{kind: EV_CELL, px: px_full[PIX_W-1:0], py: py_full[PIX_W-1:0],
                         glyph: glyph_r, fore: cfg.fg, back: cfg.bg, last: !sc && !more};
          col_nxt    = new_col;
          row_nxt    = new_row;
          cnt_nxt    = cnt_after[CNT_W-1:0];
          spaces_nxt = spaces_r - 3'd1;
          more_nxt   = more;
          if (sc)        state_nxt = BK_SCROLL;
          else if (more) state_nxt = BK_CELL;
          else           state_nxt = BK_IDLE;
        end
      end
      BK_SCROLL: begin
        if (slot_free) begin
          emit      = 1'b1;
          em.last   = !more_r;
          state_nxt = more_r ? BK_CELL : BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (slot_free) begin
      out_valid_nxt = emit;
      out_data_nxt  = em;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      spaces_r    <= '0;
      cnt_r       <= '0;
      more_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      spaces_r    <= spaces_nxt;
      cnt_r       <= cnt_nxt;
      more_r      <= more_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    glyph_r    <= glyph_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
